// File: src/phash_pkg.sv
// shared types and constants for the polynomial string hash block
package phash_pkg;

  localparam int DATA_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 1;

  localparam logic [DATA_W-1:0] BASE_RESET    = 32'd257;
  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1761471161;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BASE    = 1'b0;
  localparam logic [IDX_W-1:0] REG_MODULUS = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RH_LOAD,
    ST_RH_STEP,
    ST_RH_WB,
    ST_RC_LOAD,
    ST_RC_STEP,
    ST_RC_WB,
    ST_MB_LOAD,
    ST_MB_STEP,
    ST_ADD,
    ST_MC_LOAD,
    ST_MC_STEP,
    ST_MC_WB,
    ST_EMIT
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_TAKE,
    DP_LOAD_RH,
    DP_LOAD_RC,
    DP_LOAD_MB,
    DP_LOAD_MC,
    DP_STEP_ONE,
    DP_STEP_COEF,
    DP_ADD_HASH,
    DP_WB_HASH,
    DP_WB_COEF,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic fresh;      // hash and coefficient reduced under current modulus
    logic key_zero;   // byte on the input channel is the terminator
    logic byte_zero;  // captured byte is the terminator
    logic step_done;  // last step of a serial pass
  } dp_status_t;

endpackage

// File: src/phash_key_if.sv
// key byte channel
interface phash_key_if;
  logic                          valid;
  logic                          ready;
  logic [phash_pkg::BYTE_W-1:0]  key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

// File: src/phash_hash_if.sv
// finished hash channel
interface phash_hash_if;
  logic                          valid;
  logic                          ready;
  logic [phash_pkg::DATA_W-1:0]  hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

// File: src/phash_dp.sv
// datapath: config registers, hash state and the serial modular multiply unit
module phash_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  phash_pkg::dp_cmd_t            cmd,
  output phash_pkg::dp_status_t         status,
  input  logic                          wr_en,
  input  logic [phash_pkg::IDX_W-1:0]   wr_index,
  input  logic [phash_pkg::DATA_W-1:0]  wr_data,
  input  logic [phash_pkg::BYTE_W-1:0]  key_byte,
  output logic [phash_pkg::DATA_W-1:0]  hash_value
);

  logic [phash_pkg::DATA_W-1:0] base;
  logic [phash_pkg::DATA_W-1:0] modulus;
  logic [phash_pkg::DATA_W-1:0] hash_acc;
  logic [phash_pkg::DATA_W-1:0] coefficient;
  logic [phash_pkg::DATA_W-1:0] mod_used;
  logic                         norm;
  logic [phash_pkg::BYTE_W-1:0] byte_q;
  logic [phash_pkg::DATA_W-1:0] r;
  logic [phash_pkg::DATA_W-1:0] sh;
  logic [phash_pkg::CNT_W-1:0]  cnt;

  logic [phash_pkg::DATA_W:0]   m_ext;
  logic                         dbl;
  logic [phash_pkg::DATA_W-1:0] addend;
  logic [phash_pkg::DATA_W+1:0] s0;
  logic [phash_pkg::DATA_W+2:0] d1;
  logic [phash_pkg::DATA_W+2:0] d2;
  logic [phash_pkg::DATA_W-1:0] res;

  // modulus zero acts as 2^32
  assign m_ext = (modulus == '0) ? {1'b1, {phash_pkg::DATA_W{1'b0}}} : {1'b0, modulus};

  // step operand selection
  always_comb begin
    dbl    = 1'b1;
    addend = '0;
    case (cmd.op)
      phash_pkg::DP_STEP_ONE: begin
        addend = sh[phash_pkg::DATA_W-1] ? phash_pkg::DATA_W'(1) : '0;
      end
      phash_pkg::DP_STEP_COEF: begin
        addend = sh[phash_pkg::DATA_W-1] ? coefficient : '0;
      end
      phash_pkg::DP_ADD_HASH: begin
        dbl    = 1'b0;
        addend = hash_acc;
      end
      default: begin
        dbl    = 1'b1;
        addend = '0;
      end
    endcase
  end

  // one step: (2r or r) + addend, below 3m, then pick the in-range candidate
  always_comb begin
    s0 = (dbl ? {1'b0, r, 1'b0} : {2'b00, r}) + {2'b00, addend};
    d1 = {1'b0, s0} - {2'b00, m_ext};
    d2 = {1'b0, s0} - {1'b0, m_ext, 1'b0};
    if (!d2[phash_pkg::DATA_W+2]) begin
      res = d2[phash_pkg::DATA_W-1:0];
    end else if (!d1[phash_pkg::DATA_W+2]) begin
      res = d1[phash_pkg::DATA_W-1:0];
    end else begin
      res = s0[phash_pkg::DATA_W-1:0];
    end
  end

  assign status.fresh     = norm && (mod_used == modulus);
  assign status.key_zero  = (key_byte == '0);
  assign status.byte_zero = (byte_q == '0);
  assign status.step_done = (cnt == '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= phash_pkg::BASE_RESET;
      modulus <= phash_pkg::MODULUS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        phash_pkg::REG_BASE:    base    <= wr_data;
        phash_pkg::REG_MODULUS: modulus <= wr_data;
        default: ;
      endcase
    end
  end

  // hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc    <= '0;
      coefficient <= phash_pkg::DATA_W'(1);
      mod_used    <= phash_pkg::MODULUS_RESET;
      norm        <= 1'b1;
    end else begin
      case (cmd.op)
        phash_pkg::DP_ADD_HASH: hash_acc <= res;
        phash_pkg::DP_WB_HASH:  hash_acc <= r;
        phash_pkg::DP_WB_COEF: begin
          coefficient <= r;
          mod_used    <= modulus;
          norm        <= 1'b1;
        end
        phash_pkg::DP_EMIT: begin
          hash_acc    <= '0;
          coefficient <= phash_pkg::DATA_W'(1);
          mod_used    <= modulus;
          norm        <= (modulus != phash_pkg::DATA_W'(1));
        end
        default: ;
      endcase
    end
  end

  // serial unit registers and output beat
  always_ff @(posedge clk) begin
    case (cmd.op)
      phash_pkg::DP_TAKE: byte_q <= key_byte;
      phash_pkg::DP_LOAD_RH: begin
        r   <= '0;
        sh  <= hash_acc;
        cnt <= phash_pkg::CNT_W'(phash_pkg::DATA_W - 1);
      end
      phash_pkg::DP_LOAD_RC: begin
        r   <= '0;
        sh  <= coefficient;
        cnt <= phash_pkg::CNT_W'(phash_pkg::DATA_W - 1);
      end
      phash_pkg::DP_LOAD_MB: begin
        r   <= '0;
        sh  <= {byte_q, {(phash_pkg::DATA_W - phash_pkg::BYTE_W){1'b0}}};
        cnt <= phash_pkg::CNT_W'(phash_pkg::BYTE_W - 1);
      end
      phash_pkg::DP_LOAD_MC: begin
        r   <= '0;
        sh  <= base;
        cnt <= phash_pkg::CNT_W'(phash_pkg::DATA_W - 1);
      end
      phash_pkg::DP_STEP_ONE, phash_pkg::DP_STEP_COEF: begin
        r   <= res;
        sh  <= {sh[phash_pkg::DATA_W-2:0], 1'b0};
        cnt <= cnt - phash_pkg::CNT_W'(1);
      end
      phash_pkg::DP_EMIT: hash_value <= hash_acc;
      default: ;
    endcase
  end

endmodule

// File: src/phash_ctrl.sv
// controller: sequences reduction and multiply passes, owns the handshakes
module phash_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   key_valid,
  output logic                   key_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  phash_pkg::dp_status_t  status,
  output phash_pkg::dp_cmd_t     cmd
);

  phash_pkg::state_t state;
  phash_pkg::state_t state_next;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;
  assign key_ready = (state == phash_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      phash_pkg::ST_IDLE: begin
        if (key_valid) begin
          if (!status.fresh) begin
            state_next = phash_pkg::ST_RH_LOAD;
          end else if (status.key_zero) begin
            state_next = phash_pkg::ST_EMIT;
          end else begin
            state_next = phash_pkg::ST_MB_LOAD;
          end
        end
      end
      phash_pkg::ST_RH_LOAD: state_next = phash_pkg::ST_RH_STEP;
      phash_pkg::ST_RH_STEP: begin
        if (status.step_done) state_next = phash_pkg::ST_RH_WB;
      end
      phash_pkg::ST_RH_WB: begin
        state_next = status.byte_zero ? phash_pkg::ST_EMIT : phash_pkg::ST_RC_LOAD;
      end
      phash_pkg::ST_RC_LOAD: state_next = phash_pkg::ST_RC_STEP;
      phash_pkg::ST_RC_STEP: begin
        if (status.step_done) state_next = phash_pkg::ST_RC_WB;
      end
      phash_pkg::ST_RC_WB:   state_next = phash_pkg::ST_MB_LOAD;
      phash_pkg::ST_MB_LOAD: state_next = phash_pkg::ST_MB_STEP;
      phash_pkg::ST_MB_STEP: begin
        if (status.step_done) state_next = phash_pkg::ST_ADD;
      end
      phash_pkg::ST_ADD:     state_next = phash_pkg::ST_MC_LOAD;
      phash_pkg::ST_MC_LOAD: state_next = phash_pkg::ST_MC_STEP;
      phash_pkg::ST_MC_STEP: begin
        if (status.step_done) state_next = phash_pkg::ST_MC_WB;
      end
      phash_pkg::ST_MC_WB:   state_next = phash_pkg::ST_IDLE;
      phash_pkg::ST_EMIT: begin
        if (slot_free) state_next = phash_pkg::ST_IDLE;
      end
      default: state_next = phash_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op = phash_pkg::DP_NOP;
    case (state)
      phash_pkg::ST_IDLE:    cmd.op = key_valid ? phash_pkg::DP_TAKE : phash_pkg::DP_NOP;
      phash_pkg::ST_RH_LOAD: cmd.op = phash_pkg::DP_LOAD_RH;
      phash_pkg::ST_RH_STEP: cmd.op = phash_pkg::DP_STEP_ONE;
      phash_pkg::ST_RH_WB:   cmd.op = phash_pkg::DP_WB_HASH;
      phash_pkg::ST_RC_LOAD: cmd.op = phash_pkg::DP_LOAD_RC;
      phash_pkg::ST_RC_STEP: cmd.op = phash_pkg::DP_STEP_ONE;
      phash_pkg::ST_RC_WB:   cmd.op = phash_pkg::DP_WB_COEF;
      phash_pkg::ST_MB_LOAD: cmd.op = phash_pkg::DP_LOAD_MB;
      phash_pkg::ST_MB_STEP: cmd.op = phash_pkg::DP_STEP_COEF;
      phash_pkg::ST_ADD:     cmd.op = phash_pkg::DP_ADD_HASH;
      phash_pkg::ST_MC_LOAD: cmd.op = phash_pkg::DP_LOAD_MC;
      phash_pkg::ST_MC_STEP: cmd.op = phash_pkg::DP_STEP_COEF;
      phash_pkg::ST_MC_WB:   cmd.op = phash_pkg::DP_WB_COEF;
      phash_pkg::ST_EMIT:    cmd.op = slot_free ? phash_pkg::DP_EMIT : phash_pkg::DP_NOP;
      default:               cmd.op = phash_pkg::DP_NOP;
    endcase
  end

  // state and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phash_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == phash_pkg::DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/polynomial_string_hash.sv
// top level of the polynomial string hash block
//
//   channel   dir  payload            notes
//   keys      in   key_byte   [7:0]   zero byte ends the key
//   hashes    out  hash_value [31:0]  one beat per zero byte
//   wr_*      in   index 0 base, 1 modulus
//
// a nonzero byte runs from accept to the earliest next accept through the
// accept cycle, an 8-step byte*coefficient pass and a 32-step coefficient*base
// pass on the shared shift/subtract modular unit, one step per cycle, plus two
// loads, the add and the coefficient write-back; a zero byte goes straight to
// the emit; after a modulus change the first byte first re-reduces the hash
// (zero byte) or the hash and the coefficient (nonzero)
// reset is synchronous; the finished hash sits in an output register, so a
// stalled hashes beat holds only a zero byte that arrives behind it
module polynomial_string_hash (
  input  logic                          clk,
  input  logic                          rst,
  phash_key_if.sink                     keys,
  phash_hash_if.source                  hashes,
  input  logic                          wr_en,
  input  logic [phash_pkg::IDX_W-1:0]   wr_index,
  input  logic [phash_pkg::DATA_W-1:0]  wr_data
);

  phash_pkg::dp_cmd_t    cmd;
  phash_pkg::dp_status_t status;

  // sequencing
  phash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (keys.valid),
    .key_ready (keys.ready),
    .out_valid (hashes.valid),
    .out_ready (hashes.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state
  phash_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .key_byte   (keys.key_byte),
    .hash_value (hashes.hash_value)
  );

  // one byte in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    (keys.valid && keys.ready) |=> !keys.ready)
    else $error("key accepted while previous byte in progress");

  // a new output beat only comes from an emit
  assert property (@(posedge clk) disable iff (rst)
    $rose(hashes.valid) |-> $past(cmd.op == phash_pkg::DP_EMIT))
    else $error("output beat without emit");

  // emit never overwrites a beat still waiting
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == phash_pkg::DP_EMIT) |-> (!hashes.valid || hashes.ready))
    else $error("emit over a pending output beat");

endmodule

// File: tb/phash_hash_checker.sv
// predicts finished hashes from the key and register traffic and compares them
module phash_hash_checker
  import phash_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  phash_key_if               keys,
  phash_hash_if              hashes,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [DATA_W-1:0]  wr_data,
  output int                 err_count,
  output int                 pending
);

  // shadow copy of the block's registers and running state
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] modulus_r;
  logic [DATA_W-1:0] hash_r;
  logic [DATA_W-1:0] coef_r;

  // finished hashes still owed by the block, oldest first
  logic [DATA_W-1:0] hash_expect_q[$];

  // exact reduction; a zero modulus stands for 2^32
  function automatic logic [DATA_W-1:0] mod_reduce(input logic [63:0] v,
                                                   input logic [DATA_W-1:0] m);
    logic [63:0] r;
    if (m == '0) begin
      r = v;
    end else begin
      r = v % {32'd0, m};
    end
    return r[DATA_W-1:0];
  endfunction

  // advance the hash by one key beat
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [63:0] sum;
    logic [63:0] prod;
    if (b == '0) begin
      hash_expect_q.push_back(mod_reduce({32'd0, hash_r}, modulus_r));
      hash_r = '0;
      coef_r = 32'd1;
    end else begin
      sum    = {32'd0, hash_r} + {56'd0, b} * {32'd0, coef_r};
      prod   = {32'd0, coef_r} * {32'd0, base_r};
      hash_r = mod_reduce(sum, modulus_r);
      coef_r = mod_reduce(prod, modulus_r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base_r    = BASE_RESET;
      modulus_r = MODULUS_RESET;
      hash_r    = '0;
      coef_r    = 32'd1;
      err_count = 0;
      hash_expect_q.delete();
    end else begin
      // key beat accepted
      if (keys.valid && keys.ready) begin
        absorb_byte(keys.key_byte);
      end
      // hash beat accepted: compare with the oldest prediction
      if (hashes.valid && hashes.ready) begin
        if (hash_expect_q.size() == 0) begin
          if (err_count < 10) begin
            $display("unexpected hash beat: got %08h", hashes.hash_value);
          end
          err_count++;
        end else begin
          if (hashes.hash_value !== hash_expect_q[0]) begin
            if (err_count < 10) begin
              $display("hash_value mismatch: expected %08h got %08h",
                       hash_expect_q[0], hashes.hash_value);
            end
            err_count++;
          end
          void'(hash_expect_q.pop_front());
        end
      end
      // register write
      if (wr_en) begin
        case (wr_index)
          REG_BASE:    base_r = wr_data;
          REG_MODULUS: modulus_r = wr_data;
          default: ;
        endcase
      end
    end
    pending = hash_expect_q.size();
  end

endmodule

// File: tb/tb_polynomial_string_hash.sv
// stimulus and verdict for the polynomial string hash block
module tb_polynomial_string_hash;
  import phash_pkg::*;

  localparam int SETTLE_CYCLES = 160;   // worst byte after a modulus change, with margin
  localparam int STALL_LIMIT   = 4000;
  localparam int ITEM_TARGET   = 1700;

  logic              clk;
  logic              rst;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [DATA_W-1:0] wr_data;
  logic              steady;            // no idling on either side
  int                fail_count;
  int                hashes_pending;
  int                sent_bytes = 0;
  int                stall_cycles = 0;

  phash_key_if  keys_ch ();
  phash_hash_if hashes_ch ();

  polynomial_string_hash dut (
    .clk      (clk),
    .rst      (rst),
    .keys     (keys_ch),
    .hashes   (hashes_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  phash_hash_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys_ch),
    .hashes    (hashes_ch),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .err_count (fail_count),
    .pending   (hashes_pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hash receiver stalls at random
  always @(negedge clk) begin
    hashes_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // watchdog on cycles with no beat and no write
  always @(posedge clk) begin
    if ((keys_ch.valid && keys_ch.ready) || (hashes_ch.valid && hashes_ch.ready) || wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one key beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < 16) begin
      keys_ch.valid <= 1'b0;
      @(negedge clk);
    end
    keys_ch.valid    <= 1'b1;
    keys_ch.key_byte <= b;
    @(posedge clk);
    while (!keys_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  // random nonzero bytes, optionally closed by the terminator
  task automatic send_key(input int len, input bit terminate);
    for (int i = 0; i < len; i++) begin
      send_byte(BYTE_W'($urandom_range(1, 255)));
    end
    if (terminate) begin
      send_byte('0);
    end
  endtask

  // hold the sender until every hash is back and the block has gone quiet
  task automatic drain();
    keys_ch.valid <= 1'b0;
    @(negedge clk);
    while (hashes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write base then modulus on back-to-back cycles
  task automatic write_config(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] m);
    wr_en    <= 1'b1;
    wr_index <= REG_BASE;
    wr_data  <= b;
    @(negedge clk);
    wr_index <= REG_MODULUS;
    wr_data  <= m;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  initial begin : stimulus
    int                phase_no;
    int                phase_start;
    int                phase_len;
    int                key_len;
    logic [DATA_W-1:0] nb;
    logic [DATA_W-1:0] nm;

    phase_no         = 0;
    rst              = 1'b1;
    steady           = 1'b0;
    wr_en            = 1'b0;
    wr_index         = REG_BASE;
    wr_data          = '0;
    keys_ch.valid    = 1'b0;
    keys_ch.key_byte = '0;
    hashes_ch.ready  = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty key, then byte extremes
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h00);
    // key left open across a modulus change
    send_byte(8'h55);
    send_byte(8'hAA);
    drain();
    write_config(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_byte(8'h03);
    send_byte(8'h00);
    // base zero, largest modulus
    drain();
    write_config(32'h0000_0000, 32'hFFFF_FFFF);
    send_byte(8'hC8);
    send_byte(8'h33);
    send_byte(8'h00);
    // modulus zero wraps at 32 bits
    drain();
    write_config(32'hFFFF_FFFF, 32'h0000_0000);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    // modulus one, two terminators in a row
    drain();
    write_config(32'h0001_2345, 32'h0000_0001);
    send_byte(8'hFA);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);

    // random phases, each under its own register settings
    while (sent_bytes < ITEM_TARGET) begin
      phase_no++;
      drain();
      case ($urandom_range(0, 5))
        0:       nb = 32'h0000_0000;
        1:       nb = 32'h0000_0001;
        2:       nb = 32'hFFFF_FFFF;
        default: nb = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       nm = 32'h0000_0000;
        1:       nm = 32'h0000_0001;
        2:       nm = 32'hFFFF_FFFF;
        3:       nm = $urandom_range(2, 1000);
        4:       nm = MODULUS_RESET;
        default: nm = $urandom;
      endcase
      write_config(nb, nm);
      steady <= (phase_no == 3);
      phase_start = sent_bytes;
      phase_len   = $urandom_range(60, 160);
      while (sent_bytes - phase_start < phase_len) begin
        key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        send_key(key_len, 1'b1);
      end
      // sometimes leave a key open into the next register change
      if ($urandom_range(0, 3) == 0) begin
        send_key($urandom_range(1, 5), 1'b0);
      end
    end

    steady <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
